// File: hdl/ant_cbs_pkg.sv
package ant_cbs_pkg;

    // Channel states, as reported in state_out.
    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_RESETTING   = 4'd1;
    localparam logic [3:0] ST_SET_KEY     = 4'd2;
    localparam logic [3:0] ST_ASSIGN      = 4'd3;
    localparam logic [3:0] ST_SET_ID      = 4'd4;
    localparam logic [3:0] ST_SET_FREQ    = 4'd5;
    localparam logic [3:0] ST_SET_PERIOD  = 4'd6;
    localparam logic [3:0] ST_SET_TIMEOUT = 4'd7;
    localparam logic [3:0] ST_OPEN        = 4'd8;
    localparam logic [3:0] ST_RUNNING     = 4'd9;
    localparam logic [3:0] ST_CLOSED      = 4'd10;
    localparam logic [3:0] ST_ERROR       = 4'd11;

    // Parsed message kinds on the input channel.
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_STARTUP  = 3'd1;
    localparam logic [2:0] CMD_RESPONSE = 3'd2;
    localparam logic [2:0] CMD_DATA     = 3'd3;

    // Result kinds.
    localparam logic [1:0] KIND_COMMAND   = 2'd0;
    localparam logic [1:0] KIND_BROADCAST = 2'd1;
    localparam logic [1:0] KIND_EVENT     = 2'd2;
    localparam logic [1:0] KIND_DATA      = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MASTER_MODE      = 2'd0;
    localparam logic [1:0] REG_CHANNEL_NUMBER   = 2'd1;
    localparam logic [1:0] REG_TX_PAYLOAD       = 2'd2;
    localparam logic [1:0] REG_TX_PAYLOAD_VALID = 2'd3;

    // ANT configuration command message IDs.
    localparam logic [7:0] MSG_NONE           = 8'h00;
    localparam logic [7:0] MSG_RESET_SYSTEM   = 8'h4A;
    localparam logic [7:0] MSG_NETWORK_KEY    = 8'h46;
    localparam logic [7:0] MSG_ASSIGN_CHANNEL = 8'h42;
    localparam logic [7:0] MSG_CHANNEL_ID     = 8'h51;
    localparam logic [7:0] MSG_RF_FREQ        = 8'h45;
    localparam logic [7:0] MSG_CHANNEL_PERIOD = 8'h43;
    localparam logic [7:0] MSG_SEARCH_TIMEOUT = 8'h44;
    localparam logic [7:0] MSG_OPEN_CHANNEL   = 8'h4B;

    // Channel event decoding.
    localparam logic [7:0] EVENT_RESPONSE_ID    = 8'h01;
    localparam logic [7:0] EV_RX_SEARCH_TIMEOUT = 8'h01;
    localparam logic [7:0] EV_TX                = 8'h03;
    localparam logic [7:0] EV_CHANNEL_CLOSED    = 8'h07;
    localparam logic [7:0] CODE_OK              = 8'h00;

    localparam logic [7:0] MIN_RESPONSE_LEN = 8'd3;
    localparam logic [7:0] MIN_DATA_LEN     = 8'd9;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_length;
        logic [7:0]  channel_in;
        logic [7:0]  response_id;
        logic [7:0]  result_code;
        logic [63:0] payload_in;
    } msg_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  command_msg_id;
        logic [7:0]  channel_out;
        logic [7:0]  response_id_out;
        logic [7:0]  event_code_out;
        logic [63:0] payload_out;
        logic [3:0]  state_out;
        logic [31:0] rx_count_out;
        logic [31:0] tx_count_out;
        logic        last_of_run;
    } res_t;

    // Sequencer context carried from one item to the next.
    typedef struct packed {
        logic [3:0]  chan_state;
        logic        awaiting;
        logic [7:0]  last_cmd_id;
        logic [31:0] recv_cnt;
        logic [31:0] sent_cnt;
    } ctx_t;

    typedef struct packed {
        logic        master_mode;
        logic [7:0]  channel_number;
        logic [63:0] bcast_payload;
        logic        bcast_payload_ok;
    } cfg_t;

    // Command that a state sends on entry; MSG_NONE where there is none.
    function automatic logic [7:0] step_cmd_id(input logic [3:0] st);
        logic [7:0] id;
        case (st)
            ST_RESETTING:   id = MSG_RESET_SYSTEM;
            ST_SET_KEY:     id = MSG_NETWORK_KEY;
            ST_ASSIGN:      id = MSG_ASSIGN_CHANNEL;
            ST_SET_ID:      id = MSG_CHANNEL_ID;
            ST_SET_FREQ:    id = MSG_RF_FREQ;
            ST_SET_PERIOD:  id = MSG_CHANNEL_PERIOD;
            ST_SET_TIMEOUT: id = MSG_SEARCH_TIMEOUT;
            ST_OPEN:        id = MSG_OPEN_CHANNEL;
            default:        id = MSG_NONE;
        endcase
        return id;
    endfunction

endpackage

// File: hdl/ant_cbs_step.sv
// Next context and up to two results for one message.
module ant_cbs_step (
    input  ant_cbs_pkg::msg_t msg,
    input  ant_cbs_pkg::ctx_t ctx,
    input  ant_cbs_pkg::cfg_t cfg,
    output ant_cbs_pkg::ctx_t ctx_next,
    output ant_cbs_pkg::res_t res0,
    output ant_cbs_pkg::res_t res1,
    output logic [1:0]        nres
);

    logic       adv_ok;
    logic [3:0] adv_state;
    logic [7:0] adv_id;
    logic       adv_emit;
    ant_cbs_pkg::res_t adv_res;
    ant_cbs_pkg::res_t r0;
    ant_cbs_pkg::res_t r1;

    // Where a good reply moves the sequence from the current state.
    always_comb
    begin
        adv_ok    = 1'b1;
        adv_state = ctx.chan_state;
        case (ctx.chan_state)
            ant_cbs_pkg::ST_RESETTING,
            ant_cbs_pkg::ST_SET_KEY,
            ant_cbs_pkg::ST_ASSIGN,
            ant_cbs_pkg::ST_SET_ID,
            ant_cbs_pkg::ST_SET_FREQ:
                adv_state = ctx.chan_state + 4'd1;
            ant_cbs_pkg::ST_SET_PERIOD:
                adv_state = cfg.master_mode ? ant_cbs_pkg::ST_OPEN
                                            : ant_cbs_pkg::ST_SET_TIMEOUT;
            ant_cbs_pkg::ST_SET_TIMEOUT:
                adv_state = ant_cbs_pkg::ST_OPEN;
            ant_cbs_pkg::ST_OPEN:
                adv_state = ant_cbs_pkg::ST_RUNNING;
            default:
                adv_ok = 1'b0;
        endcase
        adv_id   = ant_cbs_pkg::step_cmd_id(adv_state);
        adv_emit = adv_ok && (adv_id != ant_cbs_pkg::MSG_NONE);

        adv_res                = '0;
        adv_res.out_kind       = ant_cbs_pkg::KIND_COMMAND;
        adv_res.command_msg_id = adv_id;
    end

    always_comb
    begin
        ctx_next = ctx;
        r0       = '0;
        r1       = '0;
        nres     = 2'd0;

        case (msg.cmd)
            ant_cbs_pkg::CMD_START:
            begin
                ctx_next.chan_state  = ant_cbs_pkg::ST_RESETTING;
                ctx_next.awaiting    = 1'b1;
                ctx_next.last_cmd_id = ant_cbs_pkg::MSG_RESET_SYSTEM;
                r0.out_kind          = ant_cbs_pkg::KIND_COMMAND;
                r0.command_msg_id    = ant_cbs_pkg::MSG_RESET_SYSTEM;
                nres                 = 2'd1;
            end
            ant_cbs_pkg::CMD_STARTUP:
            begin
                // Only the reset step waits on the startup notice, so the
                // advance always leads to a command here.
                if (ctx.chan_state == ant_cbs_pkg::ST_RESETTING && ctx.awaiting)
                begin
                    ctx_next.chan_state  = adv_state;
                    ctx_next.last_cmd_id = adv_id;
                    ctx_next.awaiting    = 1'b1;
                    r0                   = adv_res;
                    nres                 = 2'd1;
                end
            end
            ant_cbs_pkg::CMD_RESPONSE:
            begin
                if (msg.data_length >= ant_cbs_pkg::MIN_RESPONSE_LEN)
                begin
                    r0.out_kind        = ant_cbs_pkg::KIND_EVENT;
                    r0.channel_out     = msg.channel_in;
                    r0.response_id_out = msg.response_id;
                    r0.event_code_out  = msg.result_code;
                    nres               = 2'd1;
                    if (msg.response_id == ant_cbs_pkg::EVENT_RESPONSE_ID)
                    begin
                        if (msg.result_code == ant_cbs_pkg::EV_TX)
                        begin
                            if (cfg.bcast_payload_ok)
                            begin
                                ctx_next.sent_cnt = ctx.sent_cnt + 32'd1;
                                r1.out_kind       = ant_cbs_pkg::KIND_BROADCAST;
                                r1.channel_out    = cfg.channel_number;
                                r1.payload_out    = cfg.bcast_payload;
                                nres              = 2'd2;
                            end
                        end
                        else if (msg.result_code == ant_cbs_pkg::EV_CHANNEL_CLOSED)
                        begin
                            if (ctx.chan_state != ant_cbs_pkg::ST_ERROR)
                            begin
                                ctx_next.chan_state = ant_cbs_pkg::ST_CLOSED;
                            end
                        end
                        else if (msg.result_code == ant_cbs_pkg::EV_RX_SEARCH_TIMEOUT)
                        begin
                            ctx_next.chan_state = ant_cbs_pkg::ST_ERROR;
                        end
                    end
                    else if (ctx.awaiting && msg.response_id == ctx.last_cmd_id)
                    begin
                        ctx_next.awaiting = 1'b0;
                        if (msg.result_code == ant_cbs_pkg::CODE_OK)
                        begin
                            ctx_next.chan_state = adv_state;
                            if (adv_emit)
                            begin
                                ctx_next.last_cmd_id = adv_id;
                                ctx_next.awaiting    = 1'b1;
                                r1                   = adv_res;
                                nres                 = 2'd2;
                            end
                        end
                        else
                        begin
                            ctx_next.chan_state = ant_cbs_pkg::ST_ERROR;
                        end
                    end
                end
            end
            ant_cbs_pkg::CMD_DATA:
            begin
                if (msg.data_length >= ant_cbs_pkg::MIN_DATA_LEN)
                begin
                    ctx_next.recv_cnt = ctx.recv_cnt + 32'd1;
                    r0.out_kind       = ant_cbs_pkg::KIND_DATA;
                    r0.channel_out    = msg.channel_in;
                    r0.payload_out    = msg.payload_in;
                    nres              = 2'd1;
                end
            end
            default:
            begin
                nres = 2'd0;
            end
        endcase

        // Every result carries the state and counts as they stand after the item.
        res0              = r0;
        res0.state_out    = ctx_next.chan_state;
        res0.rx_count_out = ctx_next.recv_cnt;
        res0.tx_count_out = ctx_next.sent_cnt;
        res0.last_of_run  = (nres == 2'd1);
        res1              = r1;
        res1.state_out    = ctx_next.chan_state;
        res1.rx_count_out = ctx_next.recv_cnt;
        res1.tx_count_out = ctx_next.sent_cnt;
        res1.last_of_run  = 1'b1;
    end

endmodule

// File: hdl/ant_channel_bringup_sequencer.sv
// ANT channel bring-up sequencer. Each item on the msg channel is one parsed
// ANT message (start, startup notice, channel response or data message); the
// block steps the channel through reset, network key, assign, channel ID, RF
// frequency, period, search timeout (skipped in master mode) and open, and
// emits on the res channel the commands to send, event reports, broadcast
// sends and delivered data, at most two results per item, each stamped with
// the channel state and the 32-bit received and sent counts after that item.
// An accepted item is held in an input register and processed once the
// result slots are free; its results are registered in the result slots,
// and slot 0 drives the res port.
// The two result slots drain through the single res port: an item that
// yields zero or one result is taken every cycle while res_ready is high,
// and an item that yields two results holds the slots until both have left.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should be changed only while no item is in flight.
module ant_channel_bringup_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  ant_cbs_pkg::msg_t   msg,
    output logic                res_valid,
    input  logic                res_ready,
    output ant_cbs_pkg::res_t   res,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    ant_cbs_pkg::cfg_t cfg_reg;
    ant_cbs_pkg::ctx_t ctx_reg;
    ant_cbs_pkg::ctx_t ctx_next;

    logic              in_valid_reg;
    ant_cbs_pkg::msg_t in_item_reg;

    // Two result slots; slot 0 is what the res port shows.
    ant_cbs_pkg::res_t slot0_reg;
    ant_cbs_pkg::res_t slot1_reg;
    logic [1:0]        cnt_reg;

    ant_cbs_pkg::res_t step_res0;
    ant_cbs_pkg::res_t step_res1;
    logic [1:0]        step_nres;

    logic buf_free;
    logic step_fire;
    logic pop;

    ant_cbs_step u_step (
        .msg      (in_item_reg),
        .ctx      (ctx_reg),
        .cfg      (cfg_reg),
        .ctx_next (ctx_next),
        .res0     (step_res0),
        .res1     (step_res1),
        .nres     (step_nres)
    );

    assign res_valid = (cnt_reg != 2'd0);
    assign res       = slot0_reg;
    assign pop       = res_valid && res_ready;

    // The result slots can take a new item's results when they are empty or
    // when their last remaining result leaves in this cycle.
    assign buf_free  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && res_ready);
    assign step_fire = in_valid_reg && buf_free;
    assign msg_ready = !in_valid_reg || step_fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ant_cbs_pkg::REG_MASTER_MODE:      cfg_reg.master_mode      <= cfg_data[0];
                ant_cbs_pkg::REG_CHANNEL_NUMBER:   cfg_reg.channel_number   <= cfg_data[7:0];
                ant_cbs_pkg::REG_TX_PAYLOAD:       cfg_reg.bcast_payload    <= cfg_data;
                ant_cbs_pkg::REG_TX_PAYLOAD_VALID: cfg_reg.bcast_payload_ok <= cfg_data[0];
                default:                           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Input register and sequencer context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ctx_reg      <= '0;
        end
        else
        begin
            if (msg_ready)
            begin
                in_valid_reg <= msg_valid;
            end
            if (step_fire)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && msg_ready)
        begin
            in_item_reg <= msg;
        end
    end

    // Result slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (step_fire)
        begin
            cnt_reg <= step_nres;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            slot0_reg <= step_res0;
            slot1_reg <= step_res1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    // With both slots full, the shown result is the first of a pair.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !slot0_reg.last_of_run)
        else $error("first of two pending results marked as last");

    // A lone pending result always closes its run.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd1 |-> slot0_reg.last_of_run)
        else $error("lone pending result not marked as last");

    // A running channel waits on no command reply.
    a_running_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.chan_state == ant_cbs_pkg::ST_RUNNING |-> !ctx_reg.awaiting)
        else $error("running channel still awaiting a reply");

    // The received count moves by exactly one per change.
    a_rx_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.recv_cnt != $past(ctx_reg.recv_cnt)
            |-> ctx_reg.recv_cnt == $past(ctx_reg.recv_cnt) + 32'd1)
        else $error("received count jumped");

endmodule

// File: sim/ant_channel_bringup_sequencer_test.sv
module ant_channel_bringup_sequencer_test;

    import ant_cbs_pkg::*;

    // Message kinds that the sequencer does not decode; they must be dropped
    // without any result.
    localparam logic [2:0] CMD_OTHER  = 3'd4;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // A response code that is neither success nor any channel event we decode.
    localparam logic [7:0] CODE_FAIL = 8'h80;

    localparam logic [63:0] PAYLOAD_ONES = {64{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        msg_valid;
    logic        msg_ready;
    msg_t        msg;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    ant_channel_bringup_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predicted sequencer state. It is advanced once per accepted item, in
    // the order the items were accepted, so the expected results line up
    // with the order in which the block returns them.
    // ------------------------------------------------------------------
    logic [3:0]  seq_state;
    logic        seq_awaiting;
    logic [7:0]  seq_last_id;
    logic [31:0] rx_total;
    logic [31:0] tx_total;
    cfg_t        cfg_model;

    // Command that each state issues when it is entered. States past open,
    // and the unused codes, issue nothing.
    logic [7:0] entry_msg_id [0:15] = '{
        MSG_NONE, MSG_RESET_SYSTEM, MSG_NETWORK_KEY, MSG_ASSIGN_CHANNEL,
        MSG_CHANNEL_ID, MSG_RF_FREQ, MSG_CHANNEL_PERIOD, MSG_SEARCH_TIMEOUT,
        MSG_OPEN_CHANNEL, MSG_NONE, MSG_NONE, MSG_NONE,
        MSG_NONE, MSG_NONE, MSG_NONE, MSG_NONE
    };

    res_t step_results [$];     // results of the item being predicted
    res_t pending_results [$];  // results still owed by the block

    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int got_n;

    res_t  want;
    string bad;

    function automatic res_t make_result(logic [1:0] kind, logic [7:0] id,
                                         logic [7:0] chan, logic [7:0] rid,
                                         logic [7:0] code, logic [63:0] pay);
        res_t r;
        r                 = '0;
        r.out_kind        = kind;
        r.command_msg_id  = id;
        r.channel_out     = chan;
        r.response_id_out = rid;
        r.event_code_out  = code;
        r.payload_out     = pay;
        return r;
    endfunction

    // Entering a state that has a command sends it and starts waiting for
    // the matching response.
    function automatic void issue_command();
        logic [7:0] id;
        id = entry_msg_id[seq_state];
        if (id != MSG_NONE)
        begin
            seq_last_id  = id;
            seq_awaiting = 1'b1;
            step_results.push_back(make_result(KIND_COMMAND, id, 8'h00, 8'h00, 8'h00, '0));
        end
    endfunction

    // One step along the bring-up order. Master channels skip the search
    // timeout; reaching running ends the wait for replies. Any other state
    // has no next step and stays put.
    function automatic void step_forward();
        if (seq_state >= ST_RESETTING && seq_state < ST_SET_PERIOD)
            seq_state = 4'(seq_state + 4'd1);
        else if (seq_state == ST_SET_PERIOD)
            seq_state = cfg_model.master_mode ? ST_OPEN : ST_SET_TIMEOUT;
        else if (seq_state == ST_SET_TIMEOUT)
            seq_state = ST_OPEN;
        else if (seq_state == ST_OPEN)
        begin
            seq_state    = ST_RUNNING;
            seq_awaiting = 1'b0;
            return;
        end
        else
            return;
        issue_command();
    endfunction

    // Works out every result of one item and queues them, each stamped with
    // the state and the counts as they stand once the whole item is done.
    task automatic predict_channel_step(input msg_t m, output int produced);
        res_t r;
        step_results = {};
        case (m.cmd)
            CMD_START:
            begin
                seq_state = ST_RESETTING;
                issue_command();
            end
            CMD_STARTUP:
            begin
                if (seq_state == ST_RESETTING && seq_awaiting)
                    step_forward();
            end
            CMD_RESPONSE:
            begin
                if (m.data_length >= MIN_RESPONSE_LEN)
                begin
                    // Every response long enough to parse is reported.
                    step_results.push_back(make_result(KIND_EVENT, MSG_NONE, m.channel_in,
                                                       m.response_id, m.result_code, '0));
                    if (m.response_id == EVENT_RESPONSE_ID)
                    begin
                        if (m.result_code == EV_TX)
                        begin
                            if (cfg_model.bcast_payload_ok)
                            begin
                                tx_total = tx_total + 32'd1;
                                step_results.push_back(make_result(KIND_BROADCAST, MSG_NONE,
                                    cfg_model.channel_number, 8'h00, 8'h00,
                                    cfg_model.bcast_payload));
                            end
                        end
                        else if (m.result_code == EV_CHANNEL_CLOSED)
                        begin
                            if (seq_state != ST_ERROR)
                                seq_state = ST_CLOSED;
                        end
                        else if (m.result_code == EV_RX_SEARCH_TIMEOUT)
                            seq_state = ST_ERROR;
                    end
                    else if (seq_awaiting && m.response_id == seq_last_id)
                    begin
                        seq_awaiting = 1'b0;
                        if (m.result_code == CODE_OK)
                            step_forward();
                        else
                            seq_state = ST_ERROR;
                    end
                end
            end
            CMD_DATA:
            begin
                if (m.data_length >= MIN_DATA_LEN)
                begin
                    rx_total = rx_total + 32'd1;
                    step_results.push_back(make_result(KIND_DATA, MSG_NONE, m.channel_in,
                                                       8'h00, 8'h00, m.payload_in));
                end
            end
            default:
            begin
            end
        endcase
        foreach (step_results[i])
        begin
            r              = step_results[i];
            r.state_out    = seq_state;
            r.rx_count_out = rx_total;
            r.tx_count_out = tx_total;
            r.last_of_run  = (i == step_results.size() - 1);
            pending_results.push_back(r);
        end
        produced = step_results.size();
    endtask

    // ------------------------------------------------------------------
    // Clock, and the receiving side.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ready is redrawn at each falling edge. A requested hold-off keeps it low
    // while hold_left is above zero, long enough for the block to fill up
    // and push back on its input.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ready = 1'b0;
                hold_left = hold_left - 1;
            end
            else
                res_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic string show_result(res_t r);
        return $sformatf("kind=%0d id=%h ch=%h rid=%h code=%h pay=%h st=%0d rx=%0d tx=%0d last=%0b",
                         r.out_kind, r.command_msg_id, r.channel_out, r.response_id_out,
                         r.event_code_out, r.payload_out, r.state_out, r.rx_count_out,
                         r.tx_count_out, r.last_of_run);
    endfunction

    function automatic string field_differences(res_t e, res_t g);
        string s;
        s = "";
        if (g.out_kind !== e.out_kind)               s = {s, " out_kind"};
        if (g.command_msg_id !== e.command_msg_id)   s = {s, " command_msg_id"};
        if (g.channel_out !== e.channel_out)         s = {s, " channel_out"};
        if (g.response_id_out !== e.response_id_out) s = {s, " response_id_out"};
        if (g.event_code_out !== e.event_code_out)   s = {s, " event_code_out"};
        if (g.payload_out !== e.payload_out)         s = {s, " payload_out"};
        if (g.state_out !== e.state_out)             s = {s, " state_out"};
        if (g.rx_count_out !== e.rx_count_out)       s = {s, " rx_count_out"};
        if (g.tx_count_out !== e.tx_count_out)       s = {s, " tx_count_out"};
        if (g.last_of_run !== e.last_of_run)         s = {s, " last_of_run"};
        return s;
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    function automatic void note_failure(string text);
        if (fail_count < 10)
            $display("%0t: %s", $realtime, text);
        fail_count = fail_count + 1;
    endfunction

    // Each result taken by the receiver is checked against the oldest one
    // still owed.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result with nothing owed: %s", show_result(res)));
            else
            begin
                want = pending_results.pop_front();
                bad  = field_differences(want, res);
                if (bad != "")
                    note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                           bad, show_result(want), show_result(res)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sending side. All tasks below start and end just after a falling edge.
    // ------------------------------------------------------------------
    function automatic msg_t build_msg(logic [2:0] c, logic [7:0] len, logic [7:0] chan,
                                       logic [7:0] rid, logic [7:0] code, logic [63:0] pay);
        msg_t m;
        m.cmd         = c;
        m.data_length = len;
        m.channel_in  = chan;
        m.response_id = rid;
        m.result_code = code;
        m.payload_in  = pay;
        return m;
    endfunction

    // Offers one item, keeps it steady until it is taken, and then predicts
    // what it causes. Valid stays high afterwards unless the next item is
    // preceded by an idle gap.
    task automatic send_msg(input msg_t m, output int produced);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_valid = 1'b0;
            @(negedge clk);
        end
        msg       = m;
        msg_valid = 1'b1;
        do
            @(posedge clk);
        while (!msg_ready);
        predict_channel_step(m, produced);
        @(negedge clk);
    endtask

    // Waits until everything owed has come back, then lets items that cause
    // no result clear the pipeline as well.
    task automatic wait_drain();
        msg_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_MASTER_MODE:      cfg_model.master_mode      = value[0];
            REG_CHANNEL_NUMBER:   cfg_model.channel_number   = value[7:0];
            REG_TX_PAYLOAD:       cfg_model.bcast_payload    = value;
            REG_TX_PAYLOAD_VALID: cfg_model.bcast_payload_ok = value[0];
            default:
            begin
            end
        endcase
    endtask

    // Registers are only touched once the block has gone quiet.
    task automatic apply_config(input logic master, input logic [7:0] chan,
                                input logic [63:0] pay, input logic pay_ok);
        wait_drain();
        write_reg(REG_MASTER_MODE, {63'd0, master});
        write_reg(REG_CHANNEL_NUMBER, {56'd0, chan});
        write_reg(REG_TX_PAYLOAD, pay);
        write_reg(REG_TX_PAYLOAD_VALID, {63'd0, pay_ok});
    endtask

    // Start, startup notice, then a good reply to every command until the
    // channel is running.
    task automatic bring_up_to_running();
        int n;
        send_msg(build_msg(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_STARTUP, 8'd1, 8'h00, 8'h00, 8'h00, '0), n);
        while (seq_state != ST_RUNNING && seq_awaiting)
            send_msg(build_msg(CMD_RESPONSE, 8'(3 + $urandom_range(5)), 8'($urandom),
                               seq_last_id, CODE_OK, '0), n);
    endtask

    function automatic logic [7:0] response_length();
        return $urandom_range(3) == 0 ? 8'($urandom_range(3, 255)) : 8'($urandom_range(3, 8));
    endfunction

    // Most random items follow the channel's own protocol, so that the
    // sequence gets past reset and spends time running; the rest is noise
    // with every field free, including the undecoded kinds and short lengths.
    function automatic msg_t next_random_item();
        msg_t        m;
        logic [63:0] pay;
        int          pick;
        pay = {$urandom, $urandom};
        m   = build_msg(CMD_DATA, 8'($urandom_range(9, 255)), 8'($urandom), 8'h00, 8'h00, pay);
        if ($urandom_range(99) < 20)
        begin
            m.cmd         = 3'($urandom_range(7));
            m.data_length = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(10));
            case ($urandom_range(2))
                0:       m.response_id = EVENT_RESPONSE_ID;
                1:       m.response_id = seq_last_id;
                default: m.response_id = 8'($urandom);
            endcase
            m.result_code = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom);
        end
        else if (seq_state == ST_IDLE || seq_state == ST_CLOSED || seq_state == ST_ERROR
                 || $urandom_range(99) < 3)
            m.cmd = CMD_START;
        else if (seq_state == ST_RESETTING && seq_awaiting && $urandom_range(9) != 0)
            m.cmd = CMD_STARTUP;
        else if (seq_awaiting && $urandom_range(4) != 0)
        begin
            m.cmd         = CMD_RESPONSE;
            m.data_length = response_length();
            m.response_id = seq_last_id;
            m.result_code = $urandom_range(19) == 0 ? 8'($urandom_range(1, 255)) : CODE_OK;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                m.cmd = CMD_DATA;
            else
            begin
                m.cmd         = CMD_RESPONSE;
                m.data_length = response_length();
                m.response_id = EVENT_RESPONSE_ID;
                if (pick < 75)
                    m.result_code = EV_TX;
                else if (pick < 80)
                    m.result_code = EV_CHANNEL_CLOSED;
                else if (pick < 85)
                    m.result_code = EV_RX_SEARCH_TIMEOUT;
                else
                    m.result_code = 8'($urandom);
            end
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Slave channel with the registers as reset left them, so no payload is
    // loaded: the full bring-up order, the edge cases of each message kind,
    // and the routes into the error state.
    task automatic test_bringup_defaults();
        int n;
        // Startup notice and a reset reply while idle: nothing is awaited.
        send_msg(build_msg(CMD_STARTUP, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, MSG_RESET_SYSTEM, CODE_OK, '0), n);
        bring_up_to_running();
        // Transmit event with no payload loaded is only reported.
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_TX, '0), n);
        send_msg(build_msg(CMD_DATA, MIN_DATA_LEN, 8'hFF, 8'h00, 8'h00, PAYLOAD_ONES), n);
        // Too short to parse: neither reported nor counted.
        send_msg(build_msg(CMD_DATA, 8'd8, 8'h12, 8'h00, 8'h00, PAYLOAD_ONES), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd2, 8'h00, EVENT_RESPONSE_ID, EV_CHANNEL_CLOSED,
                           '0), n);
        // A reply that matches nothing is reported and changes nothing.
        send_msg(build_msg(CMD_RESPONSE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PAYLOAD_ONES), n);
        send_msg(build_msg(CMD_OTHER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PAYLOAD_ONES), n);
        send_msg(build_msg(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PAYLOAD_ONES), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_CHANNEL_CLOSED,
                           '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_RX_SEARCH_TIMEOUT,
                           '0), n);
        // Once in error, a closed event does not move the channel to closed.
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_CHANNEL_CLOSED,
                           '0), n);
        // Restart from error, then a failing reply to the network key.
        send_msg(build_msg(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_STARTUP, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, MSG_NETWORK_KEY, CODE_FAIL, '0), n);
    endtask

    // Master channel with the widest register values: the search timeout
    // step is skipped and transmit events produce broadcasts. Also covers a
    // good reply that arrives after the channel has already closed.
    task automatic test_master_broadcast();
        int n;
        apply_config(1'b1, 8'hFF, PAYLOAD_ONES, 1'b1);
        bring_up_to_running();
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_TX, '0), n);
        send_msg(build_msg(CMD_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_STARTUP, 8'd0, 8'h00, 8'h00, 8'h00, '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_CHANNEL_CLOSED,
                           '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, MSG_NETWORK_KEY, CODE_OK, '0), n);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_RX_SEARCH_TIMEOUT,
                           '0), n);
        // Smallest register values: a broadcast of an all-zero payload on channel zero.
        apply_config(1'b0, 8'h00, '0, 1'b1);
        send_msg(build_msg(CMD_RESPONSE, 8'd3, 8'h00, EVENT_RESPONSE_ID, EV_TX, '0), n);
    endtask

    // Random traffic: a fixed number of items, whether or not the block
    // answers them.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_msg(next_random_item(), n);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills and has to stall its input.
    task automatic test_backpressure();
        int n;
        apply_config(1'b0, 8'($urandom), {$urandom, $urandom}, 1'b1);
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        bring_up_to_running();
        repeat (40) send_msg(next_random_item(), n);
    endtask

    // The run is bounded by a fixed time far beyond the slowest correct run.
    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        msg_valid      = 1'b0;
        msg            = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_MASTER_MODE;
        cfg_data       = '0;
        seq_state      = ST_IDLE;
        seq_awaiting   = 1'b0;
        seq_last_id    = MSG_NONE;
        rx_total       = '0;
        tx_total       = '0;
        cfg_model      = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_bringup_defaults();
        test_master_broadcast();

        apply_config(1'b0, 8'($urandom), {$urandom, $urandom}, 1'b1);
        test_random_traffic(380, 0, 0);
        apply_config(1'b1, 8'h00, '0, 1'b1);
        test_random_traffic(380, 67, 0);
        apply_config(1'b0, 8'hFF, PAYLOAD_ONES, 1'b0);
        test_random_traffic(380, 0, 67);
        apply_config(1'b1, 8'($urandom), {$urandom, $urandom}, 1'b1);
        test_random_traffic(380, 29, 29);
        test_backpressure();

        wait_drain();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
